// ===== sv/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
// Result item layout, kind and error codes, character constants.
// No dependencies.
package jsu_pkg;

  // Results one text byte can cause (a four-byte UTF-8 sequence)
  localparam int NumRes = 4;
  localparam int CntW   = $clog2(NumRes + 1);

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [3:0] {
    ERR_NO_OPEN   = 4'd0,
    ERR_CTRL      = 4'd1,
    ERR_TRUNC_ESC = 4'd2,
    ERR_BAD_ESC   = 4'd3,
    ERR_BAD_HEX   = 4'd4,
    ERR_TRUNC_U   = 4'd5,
    ERR_NO_LOW    = 4'd6,
    ERR_BAD_LOW   = 4'd7,
    ERR_LONE_LOW  = 4'd8,
    ERR_UNTERM    = 4'd9
  } err_e;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    err_e       code;
  } res_t;

  typedef res_t [NumRes-1:0] res_vec_t;

  // Results of one item plus how many are valid
  typedef struct packed {
    res_vec_t        r;
    logic [CntW-1:0] n;
  } enc_t;

  // Characters
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowU = 8'h75;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpF = 8'h46;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChFf = 8'h0C;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChTab = 8'h09;

  // Surrogate tags in the top six bits of a 16-bit unit
  localparam logic [5:0] HighSurTag = 6'b110110;
  localparam logic [5:0] LowSurTag  = 6'b110111;
  localparam logic [20:0] SupplBase = 21'h10000;

endpackage

// ===== sv/json_string_unescape_top.sv =====
// Top level of the JSON string unescaper.
// Instantiates jsu_decode and jsu_obuf; depends on jsu_pkg.
//
// Decodes a quoted JSON string, one text byte per input transfer (tuser high
// marks end-of-input, no byte carried), into UTF-8 bytes, a string-end marker
// or an error code on the output stream; tlast flags the final result of each
// input item. An input transfer is registered, decoded once the result buffer
// is free and its results loaded into that four-entry buffer. With the output
// ready, the block takes one input per cycle for every item that gives at most
// one result; an item that gives more (a \u escape yields up to three UTF-8
// bytes, a surrogate pair four) holds the result buffer, and so the input,
// until its last result is taken. After an error, bytes are dropped until
// end-of-input, which returns the parser to its start.
module json_string_unescape_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, zero above
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);
  import jsu_pkg::*;

  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            in_eoi_q;
  logic            fire, obuf_free, load;
  res_vec_t        dec_res;
  logic [CntW-1:0] dec_cnt;
  res_t            head;

  assign fire          = in_vld_q && obuf_free;
  assign load          = fire && (dec_cnt != '0);
  assign s_axis_tready = !in_vld_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser;
    end
  end

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .eoi_i  (in_eoi_q),
    .res_o  (dec_res),
    .cnt_o  (dec_cnt)
  );

  jsu_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .res_i   (dec_res),
    .cnt_i   (dec_cnt),
    .pop_i   (m_axis_tready),
    .free_o  (obuf_free),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, head.code, head.data};
  assign m_axis_tuser = head.kind;

  // Error and string-end results carry no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_BYTE) |-> m_axis_tdata[7:0] == 8'd0)
    else $error("non-byte result carries data");

  // Byte and string-end results carry error code zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_ERR) |-> m_axis_tdata[11:8] == 4'd0)
    else $error("error code on non-error result");

  // Kind code three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("invalid result kind");

  // An input transfer always waits in the input register in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_vld_q)
    else $error("accepted item lost");

endmodule

// ===== sv/jsu_decode.sv =====
// Parser state and per-item decode for the JSON string unescaper.
// Turns one text byte or end-of-input into up to four result items.
// Depends on jsu_pkg.
module jsu_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,    // item consumed this cycle
  input  logic [7:0]           byte_i,
  input  logic                 eoi_i,
  output jsu_pkg::res_vec_t    res_o,
  output logic [jsu_pkg::CntW-1:0] cnt_o
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    PH_OPEN  = 4'd0,
    PH_BODY  = 4'd1,
    PH_ESC   = 4'd2,
    PH_HEX1  = 4'd3,
    PH_LOWBS = 4'd4,
    PH_LOWU  = 4'd5,
    PH_HEX2  = 4'd6,
    PH_DONE  = 4'd7,
    PH_ERR   = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic        bad_q, bad_d;
  logic [9:0]  hs_q, hs_d;

  logic [3:0]  hex_dig;
  logic        hex_bad;
  logic [15:0] acc_sh;
  logic        bad_all;
  logic [20:0] pair_cp;
  enc_t        enc_bmp, enc_pair, res;

  // Code point to UTF-8 bytes
  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.r[0].data = cp[7:0];
      e.n = CntW'(1);
    end else if (cp <= 21'h7FF) begin
      e.r[0].data = {3'b110, cp[10:6]};
      e.r[1].data = {2'b10, cp[5:0]};
      e.n = CntW'(2);
    end else if (cp <= 21'hFFFF) begin
      e.r[0].data = {4'b1110, cp[15:12]};
      e.r[1].data = {2'b10, cp[11:6]};
      e.r[2].data = {2'b10, cp[5:0]};
      e.n = CntW'(3);
    end else begin
      e.r[0].data = {5'b11110, cp[20:18]};
      e.r[1].data = {2'b10, cp[17:12]};
      e.r[2].data = {2'b10, cp[11:6]};
      e.r[3].data = {2'b10, cp[5:0]};
      e.n = CntW'(4);
    end
    return e;
  endfunction

  // Single error result
  function automatic enc_t err_res(input err_e code);
    enc_t e;
    e = '0;
    e.r[0].kind = KIND_ERR;
    e.r[0].code = code;
    e.n = CntW'(1);
    return e;
  endfunction

  // Hex digit value of the current byte
  always_comb begin
    hex_bad = 1'b0;
    hex_dig = 4'd0;
    if (byte_i >= ChZero && byte_i <= ChNine) begin
      hex_dig = byte_i[3:0];
    end else if ((byte_i >= ChLowA && byte_i <= ChLowF) ||
                 (byte_i >= ChUpA && byte_i <= ChUpF)) begin
      hex_dig = 4'(byte_i[3:0] + 4'd9);
    end else begin
      hex_bad = 1'b1;
    end
  end

  assign acc_sh   = {acc_q[11:0], hex_dig};
  assign bad_all  = bad_q | hex_bad;
  assign pair_cp  = SupplBase + {1'b0, hs_q, acc_sh[9:0]};
  assign enc_bmp  = utf8_enc({5'd0, acc_sh});
  assign enc_pair = utf8_enc(pair_cp);

  // Next state and results
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    hcnt_d  = hcnt_q;
    bad_d   = bad_q;
    hs_d    = hs_q;
    res     = '0;
    if (eoi_i) begin
      phase_d = PH_OPEN;
      acc_d   = '0;
      hcnt_d  = '0;
      bad_d   = 1'b0;
      hs_d    = '0;
      case (phase_q)
        PH_OPEN:            res = err_res(ERR_NO_OPEN);
        PH_BODY:            res = err_res(ERR_UNTERM);
        PH_ESC:             res = err_res(ERR_TRUNC_ESC);
        PH_HEX1, PH_HEX2:   res = err_res(ERR_TRUNC_U);
        PH_LOWBS, PH_LOWU:  res = err_res(ERR_NO_LOW);
        default:            res = '0;
      endcase
    end else begin
      case (phase_q)
        PH_OPEN: begin
          if (byte_i == ChQuote) begin
            phase_d = PH_BODY;
          end else begin
            phase_d = PH_ERR;
            res     = err_res(ERR_NO_OPEN);
          end
        end
        PH_BODY: begin
          if (byte_i == ChQuote) begin
            phase_d        = PH_DONE;
            res.r[0].kind  = KIND_END;
            res.n          = CntW'(1);
          end else if (byte_i < ChSpace) begin
            phase_d = PH_ERR;
            res     = err_res(ERR_CTRL);
          end else if (byte_i == ChBslash) begin
            phase_d = PH_ESC;
          end else begin
            res.r[0].data = byte_i;
            res.n         = CntW'(1);
          end
        end
        PH_ESC: begin
          phase_d = PH_BODY;
          res.n   = CntW'(1);
          case (byte_i)
            ChQuote:  res.r[0].data = ChQuote;
            ChBslash: res.r[0].data = ChBslash;
            ChSlash:  res.r[0].data = ChSlash;
            ChLowB:   res.r[0].data = ChBs;
            ChLowF:   res.r[0].data = ChFf;
            ChLowN:   res.r[0].data = ChLf;
            ChLowR:   res.r[0].data = ChCr;
            ChLowT:   res.r[0].data = ChTab;
            ChLowU: begin
              phase_d = PH_HEX1;
              acc_d   = '0;
              hcnt_d  = '0;
              bad_d   = 1'b0;
              res     = '0;
            end
            default: begin
              phase_d = PH_ERR;
              res     = err_res(ERR_BAD_ESC);
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          acc_d = acc_sh;
          bad_d = bad_all;
          if (hcnt_q != 2'd3) begin
            hcnt_d = 2'(hcnt_q + 2'd1);
          end else begin
            hcnt_d = '0;
            if (bad_all) begin
              phase_d = PH_ERR;
              res     = err_res(ERR_BAD_HEX);
            end else if (phase_q == PH_HEX1) begin
              if (acc_sh[15:10] == HighSurTag) begin
                hs_d    = acc_sh[9:0];
                phase_d = PH_LOWBS;
              end else if (acc_sh[15:10] == LowSurTag) begin
                phase_d = PH_ERR;
                res     = err_res(ERR_LONE_LOW);
              end else begin
                phase_d = PH_BODY;
                res     = enc_bmp;
              end
            end else if (acc_sh[15:10] != LowSurTag) begin
              phase_d = PH_ERR;
              res     = err_res(ERR_BAD_LOW);
            end else begin
              phase_d = PH_BODY;
              res     = enc_pair;
            end
          end
        end
        PH_LOWBS: begin
          if (byte_i == ChBslash) begin
            phase_d = PH_LOWU;
          end else begin
            phase_d = PH_ERR;
            res     = err_res(ERR_NO_LOW);
          end
        end
        PH_LOWU: begin
          if (byte_i == ChLowU) begin
            phase_d = PH_HEX2;
            acc_d   = '0;
            hcnt_d  = '0;
            bad_d   = 1'b0;
          end else begin
            phase_d = PH_ERR;
            res     = err_res(ERR_NO_LOW);
          end
        end
        default: res = '0;  // done, error and unused codes swallow bytes
      endcase
    end
  end

  assign res_o = res.r;
  assign cnt_o = res.n;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
      acc_q   <= '0;
      hcnt_q  <= '0;
      bad_q   <= 1'b0;
      hs_q    <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      hcnt_q  <= hcnt_d;
      bad_q   <= bad_d;
      hs_q    <= hs_d;
    end
  end

endmodule

// ===== sv/jsu_obuf.sv =====
// Result buffer for the JSON string unescaper.
// Holds the results of one item and hands them out one transfer at a time.
// Depends on jsu_pkg.
module jsu_obuf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  jsu_pkg::res_vec_t        res_i,
  input  logic [jsu_pkg::CntW-1:0] cnt_i,
  input  logic                     pop_i,   // downstream ready
  output logic                     free_o,  // may load this cycle
  output logic                     valid_o,
  output jsu_pkg::res_t            head_o,
  output logic                     last_o
);
  import jsu_pkg::*;

  res_vec_t        buf_q;
  logic [CntW-1:0] rem_q;
  logic            take;

  assign valid_o = (rem_q != '0);
  assign take    = valid_o && pop_i;
  assign last_o  = (rem_q == CntW'(1));
  assign free_o  = !valid_o || (last_o && pop_i);
  assign head_o  = buf_q[0];

  // Remaining count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= cnt_i;
    end else if (take) begin
      rem_q <= CntW'(rem_q - CntW'(1));
    end
  end

  // Payload: load whole, shift down on each transfer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= res_i;
    end else if (take) begin
      for (int i = 0; i < NumRes - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench for json_string_unescape_top: directed and random JSON string text,
// checked result by result against a behavioral decoder held in this file.
// Depends on jsu_pkg and the RTL of the unescaper.
`timescale 1ns / 100ps

module tb;
  import jsu_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int StallCycles = 200;
  localparam int DrainCycles = 8;

  // Decoder phases
  typedef enum logic [3:0] {
    P_OPEN, P_BODY, P_ESC, P_HEX1, P_LOWBS, P_LOWU, P_HEX2, P_DONE, P_ERR
  } parse_e;

  typedef struct {
    logic [7:0] data;
    kind_e      kind;
    err_e       code;
    logic       last;
  } res_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        s_axis_tuser = 1'b0;    // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [11:8] error_code
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;

  // Decoder state
  parse_e      ps = P_OPEN;
  logic [15:0] hex_acc = '0;
  logic [1:0]  hex_cnt = '0;
  logic        hex_bad = 1'b0;
  logic [9:0]  hi_sur = '0;

  res_item_t   step_q[$];
  res_item_t   pending[$];
  res_item_t   head;
  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  bit          gaps_on = 1'b1;
  bit          stall_req = 1'b0;

  json_string_unescape_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial forever #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Expected-result decoder
  // ---------------------------------------------------------------------
  function automatic void add_res(input logic [7:0] d, input kind_e k, input err_e c);
    res_item_t r;
    r.data = d;
    r.kind = k;
    r.code = c;
    r.last = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  function automatic void fail_res(input err_e c);
    ps = P_ERR;
    add_res(8'h00, KIND_ERR, c);
  endfunction

  // Code point to UTF-8
  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_res(cp[7:0], KIND_BYTE, ERR_NO_OPEN);
    end else if (cp <= 21'h7FF) begin
      add_res({3'b110, cp[10:6]}, KIND_BYTE, ERR_NO_OPEN);
      add_res({2'b10, cp[5:0]}, KIND_BYTE, ERR_NO_OPEN);
    end else if (cp <= 21'hFFFF) begin
      add_res({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NO_OPEN);
      add_res({2'b10, cp[11:6]}, KIND_BYTE, ERR_NO_OPEN);
      add_res({2'b10, cp[5:0]}, KIND_BYTE, ERR_NO_OPEN);
    end else begin
      add_res({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NO_OPEN);
      add_res({2'b10, cp[17:12]}, KIND_BYTE, ERR_NO_OPEN);
      add_res({2'b10, cp[11:6]}, KIND_BYTE, ERR_NO_OPEN);
      add_res({2'b10, cp[5:0]}, KIND_BYTE, ERR_NO_OPEN);
    end
  endfunction

  // One hex digit position; any byte counts, bad ones set the flag
  function automatic void take_digit(input logic [7:0] b);
    logic [3:0] nib;
    nib = 4'h0;
    if (b >= ChZero && b <= ChNine) nib = 4'(b - ChZero);
    else if (b >= ChLowA && b <= ChLowF) nib = 4'(b - ChLowA + 8'd10);
    else if (b >= ChUpA && b <= ChUpF) nib = 4'(b - ChUpA + 8'd10);
    else hex_bad = 1'b1;
    hex_acc = {hex_acc[11:0], nib};
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [15:0] v;
    case (ps)
      P_OPEN: begin
        if (b == ChQuote) ps = P_BODY;
        else fail_res(ERR_NO_OPEN);
      end
      P_BODY: begin
        if (b == ChQuote) begin
          ps = P_DONE;
          add_res(8'h00, KIND_END, ERR_NO_OPEN);
        end else if (b < ChSpace) begin
          fail_res(ERR_CTRL);
        end else if (b == ChBslash) begin
          ps = P_ESC;
        end else begin
          add_res(b, KIND_BYTE, ERR_NO_OPEN);
        end
      end
      P_ESC: begin
        ps = P_BODY;
        case (b)
          ChQuote:  add_res(ChQuote, KIND_BYTE, ERR_NO_OPEN);
          ChBslash: add_res(ChBslash, KIND_BYTE, ERR_NO_OPEN);
          ChSlash:  add_res(ChSlash, KIND_BYTE, ERR_NO_OPEN);
          ChLowB:   add_res(ChBs, KIND_BYTE, ERR_NO_OPEN);
          ChLowF:   add_res(ChFf, KIND_BYTE, ERR_NO_OPEN);
          ChLowN:   add_res(ChLf, KIND_BYTE, ERR_NO_OPEN);
          ChLowR:   add_res(ChCr, KIND_BYTE, ERR_NO_OPEN);
          ChLowT:   add_res(ChTab, KIND_BYTE, ERR_NO_OPEN);
          ChLowU: begin
            ps = P_HEX1;
            hex_acc = '0;
            hex_cnt = '0;
            hex_bad = 1'b0;
          end
          default:  fail_res(ERR_BAD_ESC);
        endcase
      end
      P_HEX1, P_HEX2: begin
        take_digit(b);
        if (hex_cnt < 2'd3) begin
          hex_cnt = hex_cnt + 2'd1;
        end else begin
          hex_cnt = '0;
          v = hex_acc;
          if (hex_bad) begin
            fail_res(ERR_BAD_HEX);
          end else if (ps == P_HEX1) begin
            if (v >= 16'hD800 && v <= 16'hDBFF) begin
              hi_sur = v[9:0];
              ps = P_LOWBS;
            end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
              fail_res(ERR_LONE_LOW);
            end else begin
              ps = P_BODY;
              emit_utf8({5'd0, v});
            end
          end else if (v < 16'hDC00 || v > 16'hDFFF) begin
            fail_res(ERR_BAD_LOW);
          end else begin
            ps = P_BODY;
            emit_utf8(SupplBase + {1'b0, hi_sur, 10'd0} + 21'(v[9:0]));
          end
        end
      end
      P_LOWBS: begin
        if (b != ChBslash) fail_res(ERR_NO_LOW);
        else ps = P_LOWU;
      end
      P_LOWU: begin
        if (b != ChLowU) begin
          fail_res(ERR_NO_LOW);
        end else begin
          ps = P_HEX2;
          hex_acc = '0;
          hex_cnt = '0;
          hex_bad = 1'b0;
        end
      end
      default: ;  // closing quote seen or error: byte dropped
    endcase
  endfunction

  function automatic void decode_eoi();
    case (ps)
      P_OPEN:         add_res(8'h00, KIND_ERR, ERR_NO_OPEN);
      P_BODY:         add_res(8'h00, KIND_ERR, ERR_UNTERM);
      P_ESC:          add_res(8'h00, KIND_ERR, ERR_TRUNC_ESC);
      P_HEX1, P_HEX2: add_res(8'h00, KIND_ERR, ERR_TRUNC_U);
      P_LOWBS, P_LOWU: add_res(8'h00, KIND_ERR, ERR_NO_LOW);
      default: ;
    endcase
    ps = P_OPEN;
    hex_acc = '0;
    hex_cnt = '0;
    hex_bad = 1'b0;
    hi_sur = '0;
  endfunction

  // Predict one accepted item and queue its results, last one flagged
  function automatic void unescape_item(input logic [7:0] b, input logic eoi);
    step_q.delete();
    if (eoi) decode_eoi();
    else decode_byte(b);
    if (step_q.size() != 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) pending.insert(pending.size(), step_q[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  task automatic xfer(input logic [7:0] b, input logic eoi);
    if (gaps_on) begin
      while ($urandom_range(99) < 38) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    unescape_item(b, eoi);
  endtask

  task automatic send_byte(input logic [7:0] b);
    xfer(b, 1'b0);
  endtask

  // Byte lane carries random junk on end-of-input
  task automatic send_eoi();
    xfer(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) send_byte(ChZero + 8'(nib));
    else send_byte(($urandom_range(1) ? ChUpA : ChLowA) + 8'(nib) - 8'd10);
  endtask

  task automatic send_hex4(input logic [15:0] v);
    for (int i = 3; i >= 0; i--) send_hex_digit(v[i*4 +: 4]);
  endtask

  task automatic send_escape();
    logic [7:0] esc_set [8] = '{ChQuote, ChBslash, ChSlash, ChLowB,
                                ChLowF, ChLowN, ChLowR, ChLowT};
    send_byte(ChBslash);
    send_byte(esc_set[$urandom_range(7)]);
  endtask

  task automatic send_pair(input logic [9:0] hi, input logic [9:0] lo);
    send_text("\\u");
    send_hex4({6'b110110, hi});
    send_text("\\u");
    send_hex4({6'b110111, lo});
  endtask

  // Malformed pieces of a string body
  task automatic send_broken();
    case ($urandom_range(4))
      0: begin
        send_byte(ChBslash);
        send_byte(8'($urandom_range(255)));
      end
      1: begin
        // short \u, next byte takes a digit position
        send_text("\\u");
        repeat ($urandom_range(3)) send_hex_digit(4'($urandom_range(15)));
        send_byte(8'($urandom_range(255)));
      end
      2: begin
        send_text("\\u");
        send_hex4({6'b110110, 10'($urandom_range(1023))});
        send_byte(8'($urandom_range(255)));
      end
      3: begin
        send_text("\\u");
        send_hex4({6'b110110, 10'($urandom_range(1023))});
        send_text("\\u");
        send_hex4(16'($urandom_range(16'hFFFF)));
      end
      default: begin
        send_text("\\u");
        send_hex4({6'b110111, 10'($urandom_range(1023))});
      end
    endcase
  endtask

  // Mostly well-formed string with random content, some noise
  task automatic send_random_string();
    int n_tok;
    int sel;
    if ($urandom_range(99) < 90) send_byte(ChQuote);
    else send_byte(8'($urandom_range(255)));
    n_tok = $urandom_range(4);
    for (int i = 0; i < n_tok; i++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        send_byte(8'($urandom_range(8'h20, 8'hFF)));
      end else if (sel < 50) begin
        send_escape();
      end else if (sel < 68) begin
        send_text("\\u");
        send_hex4(16'($urandom_range(16'hFFFF)));
      end else if (sel < 83) begin
        send_pair(10'($urandom_range(1023)), 10'($urandom_range(1023)));
      end else if (sel < 87) begin
        send_byte(8'($urandom_range(8'h1F)));
      end else if (sel < 91) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        send_broken();
      end
    end
    if ($urandom_range(99) < 85) begin
      send_byte(ChQuote);
      repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
    end
    send_eoi();
  endtask

  // Sender stops until every expected result is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Output side: random ready, long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        hold = StallCycles;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 38);
      end
    end
  end

  // Compare each output transfer with the oldest expected result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected result: tdata %0h tuser %0d tlast %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_cnt++;
      end else begin
        head = pending.pop_front();
        if (m_axis_tdata[7:0] !== head.data) begin
          $error("out_byte: expected %0h, got %0h", head.data, m_axis_tdata[7:0]);
          fail_cnt++;
        end
        if (m_axis_tuser !== head.kind) begin
          $error("kind: expected %0d, got %0d", head.kind, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata[11:8] !== head.code) begin
          $error("error_code: expected %0d, got %0d", head.code, m_axis_tdata[11:8]);
          fail_cnt++;
        end
        if (m_axis_tlast !== head.last) begin
          $error("last: expected %0b, got %0b", head.last, m_axis_tlast);
          fail_cnt++;
        end
        if (m_axis_tdata[15:12] !== 4'h0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata[15:12]);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    send_eoi();                           // end of text before any quote
    // top code point, high bytes pass through, bytes after the close ignored
    send_text("\"\\uDBFF\\uDFFF");
    send_byte(8'hFF);
    send_byte(8'h20);
    send_text("\"x");
    send_eoi();
    send_text("\"\\u1G");                 // text ends inside \u with a bad digit
    send_eoi();
    send_text("\"\\uD800");               // high surrogate, text ends
    send_eoi();
    send_text("x");                       // no opening quote, rest dropped
    send_byte(8'h1F);
    send_eoi();
  endtask

  task automatic test_random_strings();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < 20) send_random_string();
  endtask

  // No idling on either side
  task automatic test_full_rate();
    int unsigned start;
    start = items_sent;
    gaps_on = 1'b0;
    while (items_sent - start < 15) send_random_string();
    gaps_on = 1'b1;
  endtask

  // Receiver holds off while four-byte sequences pile up behind it
  task automatic test_backpressure();
    stall_req = 1'b1;
    send_byte(ChQuote);
    repeat (2) send_pair(10'($urandom_range(1023)), 10'($urandom_range(1023)));
    send_text("\\u20AC\"");
    send_eoi();
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_strings();
    test_full_rate();
    test_backpressure();
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/jsu_obuf.sv
sv/json_string_unescape_top.sv
dv/tb.sv
